// ----- hw/rtl/mmcal_pkg.sv -----
// ----------------------------------------------------------------------------
// mmcal_pkg
// Shared constants and types for the magnetometer min/max calibration block.
// ----------------------------------------------------------------------------
package mmcal_pkg;

    // Default sample width and scale fraction width
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SCALE_FRAC_BITS_DEF = 12;

    // Scale factor is unsigned, fixed at 16 bits
    localparam int              SCALE_W   = 16;
    localparam logic [SCALE_W-1:0] SCALE_SAT = {SCALE_W{1'b1}};

    // Quotient bits produced by the divider, plus one overflow step
    localparam int QUO_STEPS = SCALE_W;
    localparam int STEP_W    = $clog2(QUO_STEPS + 1);

    // Corrected output width and limits
    localparam int OUT_W   = 18;
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;
    localparam int OUT_TW  = ((3 * OUT_W + 7) / 8) * 8;

    // Divider status returned to the sequencer
    typedef struct packed {
        logic               done;
        logic               sat;
        logic [SCALE_W-1:0] quo;
    } t_div_res;

endpackage

// ----- hw/rtl/mmcal_div.sv -----
// ----------------------------------------------------------------------------
// mmcal_div
// Restoring divider, one quotient bit per cycle. The first step tests the
// quotient against the scale range and flags saturation; otherwise the
// following steps produce a quotient of SCALE_W bits.
// ----------------------------------------------------------------------------
module mmcal_div
    import mmcal_pkg::*;
#(
    parameter int DW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output t_div_res      o_res
);

    logic              r_busy;
    logic              r_done;
    logic              r_sat;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_dvs;
    logic [STEP_W-1:0] r_bit;
    logic [SCALE_W-1:0] r_quo;

    logic w_ge;

    // Compare remainder against the shifted divisor
    assign w_ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_sat  <= 1'b0;
                r_rem  <= i_num;
                r_dvs  <= i_den << QUO_STEPS;
                r_bit  <= STEP_W'(QUO_STEPS);
                r_quo  <= '0;
            end else if (r_busy) begin
                // Subtract where the divisor fits
                if (w_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_dvs <= r_dvs >> 1;
                if (r_bit == STEP_W'(QUO_STEPS)) begin
                    // Overflow step: quotient would exceed the scale range
                    if (w_ge) begin
                        r_sat  <= 1'b1;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_quo <= {r_quo[SCALE_W-2:0], w_ge};
                    if (r_bit == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
                r_bit <= r_bit - STEP_W'(1);
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.quo  = r_quo;

endmodule

// ----- hw/rtl/magnetometer_minmax_calibration_top.sv -----
// Sequencing: the three divisions run serially, each a setup, the divider steps
//   and a capture; an all-zero sample skips them, a zero span skips its own.
// Throughput: one request in work at a time; the next is taken once the result
//   has entered the output register; the correction shares one multiplier.
// Reset (synchronous, active low) restores min/max, bias, scale and the
//   stored sample to their initial values and empties the output register.
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_top
// Running min/max hard and soft iron calibration of a three-axis
// magnetometer. Each non-zero sample widens the per-axis range, updates
// bias and scale, and every request returns the stored sample corrected.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration_top
    import mmcal_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // tdata: sample_x, sample_y, sample_z (SAMPLE_BITS each), zero pad
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tdata: corrected_x, corrected_y, corrected_z (18 bits each), zero pad
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_TW-1:0]        m_axis_tdata,
    // tuser: ignored
    output logic                     m_axis_tuser
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SB + 19;
    localparam int PW = SB + 18;
    localparam logic [SCALE_W-1:0] SCALE_ONE =
        (SCALE_FRAC_BITS >= SCALE_W) ? SCALE_SAT : SCALE_W'(1 << SCALE_FRAC_BITS);
    localparam logic signed [PW-1:0] RND_HALF = PW'(1 << (SCALE_FRAC_BITS - 1));
    localparam logic signed [PW-1:0] LIM_HI   = PW'(OUT_MAX);
    localparam logic signed [PW-1:0] LIM_LO   = PW'(OUT_MIN);
    localparam logic signed [SB-1:0] MIN_INIT = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] MAX_INIT = {1'b1, {(SB-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SPAN,
        S_SETUP,
        S_DIV,
        S_MUL,
        S_RND,
        S_DONE
    } t_state;

    t_state r_state;
    logic [1:0] r_ax;

    logic signed [SB-1:0]   r_smp   [3];
    logic                   r_ign;
    logic signed [SB-1:0]   r_min   [3];
    logic signed [SB-1:0]   r_max   [3];
    logic signed [SB-1:0]   r_last  [3];
    logic signed [SB-1:0]   r_bias  [3];
    logic [SCALE_W-1:0]     r_scale [3];
    logic [SB+1:0]          r_total;
    logic signed [PW-1:0]   r_prod;
    logic signed [OUT_W-1:0] r_corr [3];

    logic                   r_m_valid;
    logic signed [OUT_W-1:0] r_out  [3];
    logic                   r_out_ign;

    logic [SB-1:0]          w_span  [3];
    logic signed [SB:0]     w_sum   [3];
    logic [SB-1:0]          w_span_ax;
    logic [SB+1:0]          w_den;
    logic [DW-1:0]          w_num;
    logic                   w_start;
    t_div_res               w_div;
    logic signed [SB:0]     w_diff;
    logic signed [PW-1:0]   w_mul_a;
    logic signed [PW-1:0]   w_mul_b;
    logic signed [PW-1:0]   w_rnd;
    logic signed [PW-1:0]   w_shr;
    logic signed [OUT_W-1:0] w_sat;
    logic                   w_zero;

    // Per-axis span and midpoint sum from the current range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [SB:0] v_d;
            v_d       = (SB+1)'(r_max[i]) - (SB+1)'(r_min[i]);
            w_span[i] = v_d[SB-1:0];
            w_sum[i]  = (SB+1)'(r_max[i]) + (SB+1)'(r_min[i]);
        end
    end

    // Divider operands: den = 3 * span, num = total * 2^F + den / 2
    assign w_span_ax = w_span[r_ax];
    assign w_den     = (SB+2)'({w_span_ax, 1'b0}) + (SB+2)'(w_span_ax);
    assign w_num     = (DW'(r_total) << SCALE_FRAC_BITS) + DW'(w_den >> 1);
    assign w_start   = (r_state == S_SETUP) && (w_span_ax != '0);

    mmcal_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (DW'(w_den)),
        .o_res   (w_div)
    );

    // Shared multiplier operands: bias-removed sample by scale
    assign w_diff  = (SB+1)'(r_last[r_ax]) - (SB+1)'(r_bias[r_ax]);
    assign w_mul_a = PW'(w_diff);
    assign w_mul_b = PW'(signed'({1'b0, r_scale[r_ax]}));

    // Round half up, drop fraction bits, saturate
    assign w_rnd = r_prod + RND_HALF;
    assign w_shr = w_rnd >>> SCALE_FRAC_BITS;
    always_comb begin
        if (w_shr > LIM_HI) begin
            w_sat = OUT_W'(LIM_HI);
        end else if (w_shr < LIM_LO) begin
            w_sat = OUT_W'(LIM_LO);
        end else begin
            w_sat = w_shr[OUT_W-1:0];
        end
    end

    assign w_zero = (s_axis_tdata[3*SB-1:0] == '0);

    // Sequencer, calibration state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ax      <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_min[i]   <= MIN_INIT;
                r_max[i]   <= MAX_INIT;
                r_last[i]  <= '0;
                r_bias[i]  <= '0;
                r_scale[i] <= SCALE_ONE;
            end
        end else begin
            // Drop the result once taken, unless a new one loads now
            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_smp[i] <= s_axis_tdata[i*SB +: SB];
                        end
                        r_ign   <= w_zero;
                        r_ax    <= '0;
                        r_state <= w_zero ? S_MUL : S_UPD;
                    end
                end
                S_UPD: begin
                    // Store the sample and widen the range
                    for (int i = 0; i < 3; i++) begin
                        r_last[i] <= r_smp[i];
                        if (r_smp[i] < r_min[i]) begin
                            r_min[i] <= r_smp[i];
                        end
                        if (r_smp[i] > r_max[i]) begin
                            r_max[i] <= r_smp[i];
                        end
                    end
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    // Floor of the midpoint, and the sum of spans
                    for (int i = 0; i < 3; i++) begin
                        r_bias[i] <= w_sum[i][SB:1];
                    end
                    r_total <= (SB+2)'(w_span[0]) + (SB+2)'(w_span[1])
                             + (SB+2)'(w_span[2]);
                    r_ax    <= '0;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    if (w_span_ax == '0) begin
                        // Zero span: unity scale, skip the division
                        r_scale[r_ax] <= SCALE_ONE;
                        if (r_ax == 2'd2) begin
                            r_ax    <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_scale[r_ax] <= w_div.sat ? SCALE_SAT : w_div.quo;
                        if (r_ax == 2'd2) begin
                            r_ax    <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_corr[r_ax] <= w_sat;
                    if (r_ax == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_out[i] <= r_corr[i];
                        end
                        r_out_ign <= r_ign;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_out_ign;
    assign m_axis_tdata  = OUT_TW'({r_out[2], r_out[1], r_out[0]});

endmodule

// ----- tb/magnetometer_minmax_calibration_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_top_tb
// Streams raw three-axis samples into the min/max calibration block and
// checks every returned correction against a cycle-free model of the running
// min/max, bias and scale. A directed opening covers the start-up state,
// ignored all-zero requests, zero spans, scale saturation and the field
// extremes. Random requests with slowly widening y and z ranges follow,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration_top_tb;
    import mmcal_pkg::*;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
    localparam int FRAC_W       = SCALE_FRAC_BITS_DEF;
    localparam int IN_TW        = ((3 * SAMPLE_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 630;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 80;

    typedef logic signed [SAMPLE_W-1:0] t_axis;

    typedef struct {
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic signed [OUT_W-1:0] cz;
        logic                    ign;
    } t_correction;

    // Running calibration state and the corrections still owed by the block
    class calibration_tracker;
        int          axis_lo [3];
        int          axis_hi [3];
        int          held    [3];
        int          bias    [3];
        int unsigned scale   [3];
        t_correction owed_q  [$];
        int          error_count;

        function new();
            for (int i = 0; i < 3; i++) begin
                axis_lo[i] = (1 <<< (SAMPLE_W - 1)) - 1;
                axis_hi[i] = -(1 <<< (SAMPLE_W - 1));
                held[i]    = 0;
                bias[i]    = 0;
                scale[i]   = unity_scale();
            end
            error_count = 0;
        endfunction

        function int unsigned unity_scale();
            longint one;
            one = longint'(1) <<< FRAC_W;
            return (one > longint'(SCALE_SAT)) ? int'(SCALE_SAT) : int'(one);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Remove the bias, apply the scale, round halves upward and saturate
        function logic signed [OUT_W-1:0] correct_axis(int i);
            longint prod;
            longint r;
            prod = longint'(held[i] - bias[i]) * longint'(scale[i]);
            r    = (prod + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
            if (r > OUT_MAX) r = OUT_MAX;
            if (r < OUT_MIN) r = OUT_MIN;
            return r[OUT_W-1:0];
        endfunction

        // Update the calibration for an accepted request and owe its result
        function void note_sample(t_axis x, t_axis y, t_axis z);
            int          s [3];
            longint      span [3];
            longint      total;
            longint      den;
            longint      num;
            longint      quo;
            t_correction c;
            s[0]  = x;
            s[1]  = y;
            s[2]  = z;
            c.ign = (s[0] == 0) && (s[1] == 0) && (s[2] == 0);
            if (!c.ign) begin
                total = 0;
                for (int i = 0; i < 3; i++) begin
                    held[i] = s[i];
                    if (s[i] < axis_lo[i]) axis_lo[i] = s[i];
                    if (s[i] > axis_hi[i]) axis_hi[i] = s[i];
                    bias[i] = (axis_hi[i] + axis_lo[i]) >>> 1;
                    span[i] = longint'(axis_hi[i]) - longint'(axis_lo[i]);
                    total  += span[i];
                end
                for (int i = 0; i < 3; i++) begin
                    if (span[i] <= 0) begin
                        scale[i] = unity_scale();
                    end else begin
                        den      = 3 * span[i];
                        num      = (total <<< FRAC_W) + den / 2;
                        quo      = num / den;
                        scale[i] = (quo > longint'(SCALE_SAT)) ? int'(SCALE_SAT) : int'(quo);
                    end
                end
            end
            c.cx = correct_axis(0);
            c.cy = correct_axis(1);
            c.cz = correct_axis(2);
            owed_q.push_back(c);
        endfunction

        // Compare a returned correction with the oldest one owed
        function void check_correction(logic [OUT_TW-1:0] data, logic flag);
            t_correction c;
            if (owed_q.size() == 0) begin
                $error("correction returned with no request pending: tdata=%h", data);
                error_count++;
                return;
            end
            c = owed_q.pop_front();
            if (data[OUT_W-1:0] !== c.cx) begin
                $error("corrected_x: expected %0d, got %0d", c.cx,
                       $signed(data[OUT_W-1:0]));
                error_count++;
            end
            if (data[2*OUT_W-1:OUT_W] !== c.cy) begin
                $error("corrected_y: expected %0d, got %0d", c.cy,
                       $signed(data[2*OUT_W-1:OUT_W]));
                error_count++;
            end
            if (data[3*OUT_W-1:2*OUT_W] !== c.cz) begin
                $error("corrected_z: expected %0d, got %0d", c.cz,
                       $signed(data[3*OUT_W-1:2*OUT_W]));
                error_count++;
            end
            if (flag !== c.ign) begin
                $error("ignored: expected %0b, got %0b", c.ign, flag);
                error_count++;
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // tdata: sample_x, sample_y, sample_z
    logic [IN_TW-1:0]  s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // tdata: corrected_x, corrected_y, corrected_z, zero pad
    logic [OUT_TW-1:0] m_axis_tdata;
    // tuser: ignored
    logic              m_axis_tuser;

    calibration_tracker calib = new();
    int                 cycle_count = 0;
    bit                 sender_quiet = 1'b0;

    magnetometer_minmax_calibration_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("magnetometer_minmax_calibration_top_tb failed");
            $finish;
        end
    end

    // Offer one sample after a random gap and hold it until accepted
    task automatic send_sample(input t_axis x, input t_axis y, input t_axis z);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        calib.note_sample(x, y, z);
    endtask

    // Draw an axis value from a window around a centre, clipped to the range
    function automatic t_axis draw_axis(int centre, int width);
        int v;
        v = centre - width / 2 + int'($urandom_range(0, width));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    // Drain corrections with random stalls and one long hold-off
    initial begin : drain
        int stall;
        int results;
        results = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results == HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = (results >= 400 && results < 500) ? 0 : $urandom_range(0, 4);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    // stall either before the result shows up or after it
                    if ($urandom_range(0, 1)) begin
                        do @(posedge i_clk); while (!m_axis_tvalid);
                    end
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            calib.check_correction(m_axis_tdata, m_axis_tuser);
            results++;
        end
    end

    // Reset, directed requests, random requests, then wait out the tail
    initial begin : stimulus
        int    accepted;
        int    pick;
        int    y_width;
        int    z_width;
        t_axis x;
        t_axis y;
        t_axis z;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before any sample, then first sample with zero span on every axis
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd100, -16'sd50, 16'sd7);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        // unit span on x only, then y widened while x stays put
        send_sample(16'sd101, -16'sd50, 16'sd7);
        send_sample(16'sd101, 16'sd200, 16'sd7);
        // partly zero samples still calibrate
        send_sample(16'sd0, 16'sd0, -16'sd9);
        send_sample(16'sd0, 16'sd3, 16'sd0);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
        // x to both extremes: y and z scales saturate
        send_sample(16'sd32767, 16'sd5, 16'sd0);
        send_sample(-16'sd32768, 16'sd5, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd32767, 16'sd1);
        send_sample(16'sd1, 16'sd0, -16'sd32768);
        // alternating bit patterns on every axis
        send_sample(16'sh5555, 16'sh5555, 16'sh5555);
        send_sample(16'shAAAA, 16'shAAAA, 16'shAAAA);
        send_sample(16'sd0, 16'sd0, 16'sd0);

        // random samples; y and z ranges widen at different rates
        accepted = 0;
        while (accepted < RANDOM_ITEMS) begin
            sender_quiet = (accepted >= 250 && accepted < 350);
            pick    = $urandom_range(0, 99);
            y_width = 512 + accepted * 64;
            z_width = 256 + (accepted * accepted) / 8;
            if (pick < 8) begin
                send_sample(16'sd0, 16'sd0, 16'sd0);
            end else begin
                x = draw_axis(0, 65535);
                y = draw_axis(200, (y_width > 65535) ? 65535 : y_width);
                z = draw_axis(-100, (z_width > 65535) ? 65535 : z_width);
                if (pick < 12) begin
                    case ($urandom_range(0, 2))
                        0: x = '0;
                        1: y = '0;
                        default: z = '0;
                    endcase
                end
                if (accepted == RANDOM_ITEMS - 2) y = -16'sd32768;
                if (accepted == RANDOM_ITEMS - 1) z = 16'sd32767;
                send_sample(x, y, z);
                if (x != 0 || y != 0 || z != 0) accepted++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the last corrections drain, then watch for stray ones
        while (calib.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (calib.error_count == 0) begin
            $display("magnetometer_minmax_calibration_top_tb passed");
        end else begin
            $display("magnetometer_minmax_calibration_top_tb failed");
        end
        $finish;
    end

endmodule
